>>> design/lsd_pkg.sv
// lsd_pkg: shared types and constants for the LIFO stack with delete.
// Used by lsd_cell and lifo_stack_with_delete_core. No dependencies.
`default_nettype none

package lsd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 5;   // width of the reported entry count
  localparam int unsigned DEPTH_DEF = 16;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;  // -1

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;   // shift down, top takes the new word
    logic pop;    // shift up, bottom empties
    logic del;    // cells at or below the first match shift up
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/lsd_cell.sv
// lsd_cell: one storage slot of the stack. Holds a word and an occupied bit,
// compares against the search key and passes the match flag downward.
// Depends on lsd_pkg.
`default_nettype none

module lsd_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lsd_pkg::cell_cmd_t               cmd_i,
  input  wire logic signed [lsd_pkg::WORD_W-1:0] key_i,
  // neighbor nearer the top (or the input word for the top cell)
  input  wire logic signed [lsd_pkg::WORD_W-1:0] up_data_i,
  input  wire logic                             up_valid_i,
  // neighbor nearer the bottom
  input  wire logic signed [lsd_pkg::WORD_W-1:0] dn_data_i,
  input  wire logic                             dn_valid_i,
  input  wire logic                             match_i,   // a match sits above
  output logic                                  match_o,
  output logic signed [lsd_pkg::WORD_W-1:0]     data_o,
  output logic                                  valid_o
);

  logic signed [lsd_pkg::WORD_W-1:0] data_q, data_d;
  logic                              valid_q, valid_d;
  logic                              hit;

  assign hit     = valid_q && (data_q == key_i);
  assign match_o = match_i | hit;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (cmd_i.push) begin
      data_d  = up_data_i;
      valid_d = up_valid_i;
    end else if (cmd_i.pop || (cmd_i.del && match_o)) begin
      data_d  = dn_data_i;
      valid_d = dn_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

>>> design/lifo_stack_with_delete_core.sv
// lifo_stack_with_delete_core: top level of the LIFO stack with delete.
// Instantiates a row of lsd_cell slots; uses lsd_pkg.
//
// The stack is a row of DEPTH cells with the top of stack in cell 0. Push
// shifts every cell one place toward the bottom, pop shifts toward the top,
// and delete compares all cells in parallel against the key, then shifts up
// only the cells at and below the first match from the top, closing the gap.
// The result of each accepted request appears in an output register on the
// next cycle, and a new request is taken in the same cycle the previous
// result is taken, so the block sustains one request per cycle when the
// output is not stalled. The critical path is the 32-bit compare in
// a cell plus the one-bit match flag rippling through all DEPTH cells.
// A push to a full stack is dropped with a full status; pop or peek on an
// empty stack returns -1. entry_count reports the count modulo 32.
`default_nettype none

module lifo_stack_with_delete_core #(
  parameter int unsigned DEPTH = lsd_pkg::DEPTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [1:0]                           operation_i,
  input  wire logic signed [lsd_pkg::WORD_W-1:0]    value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [lsd_pkg::WORD_W-1:0]         result_value_o,
  output logic [1:0]                                status_o,
  output logic [lsd_pkg::COUNT_W-1:0]               entry_count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [lsd_pkg::WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]                  cell_valid;
  logic [DEPTH:0]                    cell_match;
  lsd_pkg::cell_cmd_t                cmd;

  logic          accept;
  lsd_pkg::op_e  op;
  logic          empty, full, found;
  logic [CW-1:0] count_q, count_d;

  logic                              out_valid_q, out_valid_d;
  logic signed [lsd_pkg::WORD_W-1:0] result_q, result_d;
  lsd_pkg::status_e                  status_q, status_d;
  logic [lsd_pkg::COUNT_W-1:0]       entry_count_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign op         = lsd_pkg::op_e'(operation_i);
  assign empty      = ~cell_valid[0];
  assign full       = cell_valid[DEPTH-1];
  assign found      = cell_match[DEPTH];
  assign cell_match[0] = 1'b0;

  // ---------------------------------------------------------------------------
  // Cell row
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [lsd_pkg::WORD_W-1:0] up_data, dn_data;
    logic                              up_valid, dn_valid;

    if (i == 0) begin : g_top
      assign up_data  = value_i;
      assign up_valid = 1'b1;
    end else begin : g_mid
      assign up_data  = cell_data[i-1];
      assign up_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign dn_data  = '0;
      assign dn_valid = 1'b0;
    end else begin : g_low
      assign dn_data  = cell_data[i+1];
      assign dn_valid = cell_valid[i+1];
    end

    lsd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .key_i      (value_i),
      .up_data_i  (up_data),
      .up_valid_i (up_valid),
      .dn_data_i  (dn_data),
      .dn_valid_i (dn_valid),
      .match_i    (cell_match[i]),
      .match_o    (cell_match[i+1]),
      .data_o     (cell_data[i]),
      .valid_o    (cell_valid[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    result_d = '0;
    status_d = lsd_pkg::ST_OK;
    case (op)
      lsd_pkg::OP_PUSH: begin
        if (full) begin
          status_d = lsd_pkg::ST_FULL;
        end else begin
          cmd.push = accept;
          count_d  = count_q + CW'(1);
        end
      end
      lsd_pkg::OP_POP, lsd_pkg::OP_PEEK: begin
        if (empty) begin
          result_d = lsd_pkg::EMPTY_WORD;
          status_d = lsd_pkg::ST_EMPTY;
        end else begin
          result_d = cell_data[0];
          if (op == lsd_pkg::OP_POP) begin
            cmd.pop = accept;
            count_d = count_q - CW'(1);
          end
        end
      end
      lsd_pkg::OP_DELETE: begin
        cmd.del = accept;
        if (empty) begin
          status_d = lsd_pkg::ST_EMPTY;
        end else if (!found) begin
          status_d = lsd_pkg::ST_NOT_FOUND;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      default: begin
        status_d = lsd_pkg::ST_OK;
      end
    endcase
  end

  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // result beat registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q      <= result_d;
      status_q      <= status_d;
      entry_count_q <= lsd_pkg::COUNT_W'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign entry_count_o  = entry_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == 32'($countones(cell_valid)))
    else $error("count disagrees with occupied cells");

  a_cells_packed_to_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the top");

  a_pop_decrements : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == lsd_pkg::OP_POP && !empty) |=> count_q == $past(count_q) - CW'(1))
    else $error("pop did not remove one entry");

  a_empty_reports_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == lsd_pkg::ST_EMPTY) |-> entry_count_o == '0)
    else $error("empty status with nonzero count");

endmodule

`default_nettype wire
